>>> src/rv64m_multiply_divide_unit_core_defines.svh
// ------------------------------------------------------------------------
// Assertion macros for the RV64M multiply/divide unit.
// Shared property forms that are clocked on clk and held off during reset.
// ------------------------------------------------------------------------
`ifndef RV64M_MULTIPLY_DIVIDE_UNIT_CORE_DEFINES_SVH
`define RV64M_MULTIPLY_DIVIDE_UNIT_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MDU_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mdu check failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define MDU_ASSERT_DELAY(label, ante, dly, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error("mdu latency check failed");

`endif

>>> src/mdu_pkg.sv
// ------------------------------------------------------------------------
// mdu_pkg
// Types, operation codes and helpers of the RV64M multiply/divide unit.
// ------------------------------------------------------------------------
package mdu_pkg;

	localparam int XLEN = 64;

	localparam logic [2:0] CMD_MUL    = 3'd0;
	localparam logic [2:0] CMD_MULH   = 3'd1;
	localparam logic [2:0] CMD_MULHSU = 3'd2;
	localparam logic [2:0] CMD_MULHU  = 3'd3;
	localparam logic [2:0] CMD_DIV    = 3'd4;
	localparam logic [2:0] CMD_DIVU   = 3'd5;
	localparam logic [2:0] CMD_REM    = 3'd6;
	localparam logic [2:0] CMD_REMU   = 3'd7;

	typedef struct packed {
		logic [2:0]      cmd;
		logic            word_mode;
		logic [XLEN-1:0] operand_a;
		logic [XLEN-1:0] operand_b;
		logic [4:0]      dest_reg;
	} mdu_req_t;

	typedef struct packed {
		logic [XLEN-1:0] result_value;
		logic [4:0]      dest_tag;
		logic            illegal_op;
	} mdu_rsp_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       word_mode;
		logic [4:0] dest_reg;
		logic       illegal;
		logic       neg_q;
		logic       neg_r;
	} mdu_meta_t;

	function automatic logic [XLEN-1:0] sext32(input logic [XLEN-1:0] v);
		sext32 = {{(XLEN-32){v[31]}}, v[31:0]};
	endfunction

endpackage

>>> src/mdu_mul.sv
// ------------------------------------------------------------------------
// mdu_mul
// Three-stage 64x64 multiplier built from four 32x32 partial products,
// with sign correction of the upper half for the signed high forms.
// ------------------------------------------------------------------------
module mdu_mul
	import mdu_pkg::*;
(
	input  logic            clk,
	input  logic [XLEN-1:0] a,
	input  logic [XLEN-1:0] b,
	input  logic            a_sgn,
	input  logic            b_sgn,
	output logic [XLEN-1:0] lo,
	output logic [XLEN-1:0] hi
);

	localparam int H = XLEN / 2;

	logic [XLEN-1:0]   pp_ll_s2, pp_lh_s2, pp_hl_s2, pp_hh_s2, corr_s2;
	logic [2*XLEN-1:0] full_s3;
	logic [XLEN-1:0]   corr_s3, lo_s4, hi_s4;

	always_ff @(posedge clk) begin
		pp_ll_s2 <= a[H-1:0] * b[H-1:0];
		pp_lh_s2 <= a[H-1:0] * b[XLEN-1:H];
		pp_hl_s2 <= a[XLEN-1:H] * b[H-1:0];
		pp_hh_s2 <= a[XLEN-1:H] * b[XLEN-1:H];
		corr_s2  <= ((a_sgn && a[XLEN-1]) ? b : '0) + ((b_sgn && b[XLEN-1]) ? a : '0);
	end

	always_ff @(posedge clk) begin
		full_s3 <= {pp_hh_s2, pp_ll_s2}
			+ {{H{1'b0}}, pp_lh_s2, {H{1'b0}}}
			+ {{H{1'b0}}, pp_hl_s2, {H{1'b0}}};
		corr_s3 <= corr_s2;
	end

	always_ff @(posedge clk) begin
		lo_s4 <= full_s3[XLEN-1:0];
		hi_s4 <= full_s3[2*XLEN-1:XLEN] - corr_s3;
	end

	assign lo = lo_s4;
	assign hi = hi_s4;

endmodule

>>> src/mdu_div.sv
// ------------------------------------------------------------------------
// mdu_div
// Fully pipelined unsigned restoring divider, one quotient bit per stage.
// Division by zero yields an all-ones quotient and the dividend as remainder.
// ------------------------------------------------------------------------
module mdu_div
	import mdu_pkg::*;
(
	input  logic            clk,
	input  logic [XLEN-1:0] dividend,
	input  logic [XLEN-1:0] divisor,
	output logic [XLEN-1:0] quotient,
	output logic [XLEN-1:0] remainder
);

	logic [XLEN-1:0] rem_pipe [XLEN];
	logic [XLEN-1:0] quo_pipe [XLEN];
	logic [XLEN-1:0] dvs_pipe [XLEN];

	for (genvar i = 0; i < XLEN; i++) begin : g_step
		logic [XLEN-1:0] r_in, n_in, d_in;
		logic [XLEN:0]   trial, diff;
		logic            ge;

		if (i == 0) begin : g_first
			assign r_in = '0;
			assign n_in = dividend;
			assign d_in = divisor;
		end else begin : g_next
			assign r_in = rem_pipe[i-1];
			assign n_in = quo_pipe[i-1];
			assign d_in = dvs_pipe[i-1];
		end

		assign trial = {r_in, n_in[XLEN-1]};
		assign diff  = trial - {1'b0, d_in};
		assign ge    = !diff[XLEN];

		always_ff @(posedge clk) begin
			rem_pipe[i] <= ge ? diff[XLEN-1:0] : trial[XLEN-1:0];
			quo_pipe[i] <= {n_in[XLEN-2:0], ge};
			dvs_pipe[i] <= d_in;
		end
	end

	assign quotient  = quo_pipe[XLEN-1];
	assign remainder = rem_pipe[XLEN-1];

endmodule

>>> src/rv64m_multiply_divide_unit_core.sv
// ------------------------------------------------------------------------
// rv64m_multiply_divide_unit_core
// Executes one RV64M multiply or divide instruction per request.
// ------------------------------------------------------------------------
// A request is taken on any cycle with start high; busy is always low, so a
// new request may enter every cycle. Each request's result is marked by a
// single-cycle done strobe. The pipeline depth is set by the divider, which
// resolves one quotient bit per pipeline stage; multiply results are delayed
// to the same slot so results leave in request order. The receiver cannot
// stall the unit.
module rv64m_multiply_divide_unit_core
	import mdu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  mdu_req_t req,
	output logic     done,
	output mdu_rsp_t rsp
);

	`include "rv64m_multiply_divide_unit_core_defines.svh"

	localparam int MUL_DLY = XLEN - 3;
	localparam int LAT     = XLEN + 2;

	logic            take, is_div_sgn;
	logic [XLEN-1:0] da, db;
	mdu_meta_t       meta_d;

	logic            valid_s1;
	mdu_meta_t       meta_s1;
	logic [XLEN-1:0] mul_a_s1, mul_b_s1, dvd_s1, dvs_s1;
	logic            a_sgn_s1, b_sgn_s1;

	logic [XLEN-1:0] mul_lo, mul_hi, quo, rem;
	logic [XLEN-1:0] lo_pipe [MUL_DLY];
	logic [XLEN-1:0] hi_pipe [MUL_DLY];
	logic            valid_pipe [XLEN];
	mdu_meta_t       meta_pipe  [XLEN];

	mdu_meta_t       m_end;
	logic [XLEN-1:0] res;

	logic            done_q, word_q;
	mdu_rsp_t        rsp_q;

	assign busy = 1'b0;
	assign take = start && !busy;

	assign is_div_sgn = (req.cmd == CMD_DIV) || (req.cmd == CMD_REM);
	assign da = req.word_mode ? (is_div_sgn ? sext32(req.operand_a)
		: {{(XLEN-32){1'b0}}, req.operand_a[31:0]}) : req.operand_a;
	assign db = req.word_mode ? (is_div_sgn ? sext32(req.operand_b)
		: {{(XLEN-32){1'b0}}, req.operand_b[31:0]}) : req.operand_b;

	always_comb begin
		meta_d.cmd       = req.cmd;
		meta_d.word_mode = req.word_mode;
		meta_d.dest_reg  = req.dest_reg;
		meta_d.illegal   = req.word_mode && ((req.cmd == CMD_MULH)
			|| (req.cmd == CMD_MULHSU) || (req.cmd == CMD_MULHU));
		meta_d.neg_q     = is_div_sgn && (da[XLEN-1] ^ db[XLEN-1]) && (db != '0);
		meta_d.neg_r     = is_div_sgn && da[XLEN-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		meta_s1  <= meta_d;
		mul_a_s1 <= req.operand_a;
		mul_b_s1 <= req.operand_b;
		a_sgn_s1 <= !req.word_mode && ((req.cmd == CMD_MULH) || (req.cmd == CMD_MULHSU));
		b_sgn_s1 <= !req.word_mode && (req.cmd == CMD_MULH);
		dvd_s1   <= (is_div_sgn && da[XLEN-1]) ? (~da + 1'b1) : da;
		dvs_s1   <= (is_div_sgn && db[XLEN-1]) ? (~db + 1'b1) : db;
	end

	mdu_mul u_mul (
		.clk   (clk),
		.a     (mul_a_s1),
		.b     (mul_b_s1),
		.a_sgn (a_sgn_s1),
		.b_sgn (b_sgn_s1),
		.lo    (mul_lo),
		.hi    (mul_hi)
	);

	mdu_div u_div (
		.clk       (clk),
		.dividend  (dvd_s1),
		.divisor   (dvs_s1),
		.quotient  (quo),
		.remainder (rem)
	);

	for (genvar i = 0; i < MUL_DLY; i++) begin : g_mul_dly
		always_ff @(posedge clk) begin
			lo_pipe[i] <= (i == 0) ? mul_lo : lo_pipe[(i == 0) ? 0 : i-1];
			hi_pipe[i] <= (i == 0) ? mul_hi : hi_pipe[(i == 0) ? 0 : i-1];
		end
	end

	for (genvar i = 0; i < XLEN; i++) begin : g_meta
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_pipe[i] <= 1'b0;
			end else begin
				valid_pipe[i] <= (i == 0) ? valid_s1 : valid_pipe[(i == 0) ? 0 : i-1];
			end
		end
		always_ff @(posedge clk) begin
			meta_pipe[i] <= (i == 0) ? meta_s1 : meta_pipe[(i == 0) ? 0 : i-1];
		end
	end

	assign m_end = meta_pipe[XLEN-1];

	always_comb begin
		unique case (m_end.cmd)
			CMD_MUL:                         res = lo_pipe[MUL_DLY-1];
			CMD_MULH, CMD_MULHSU, CMD_MULHU: res = hi_pipe[MUL_DLY-1];
			CMD_DIV, CMD_DIVU:               res = m_end.neg_q ? (~quo + 1'b1) : quo;
			CMD_REM, CMD_REMU:               res = m_end.neg_r ? (~rem + 1'b1) : rem;
			default:                         res = '0;
		endcase
		if (m_end.word_mode) begin
			res = sext32(res);
		end
		if (m_end.illegal) begin
			res = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_pipe[XLEN-1];
		end
	end

	always_ff @(posedge clk) begin
		rsp_q.result_value <= res;
		rsp_q.dest_tag     <= m_end.dest_reg;
		rsp_q.illegal_op   <= m_end.illegal;
		word_q             <= m_end.word_mode;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`MDU_ASSERT_DELAY(a_latency, start, LAT, done)
	`MDU_ASSERT_IMPL(a_illegal_zero, done && rsp.illegal_op, rsp.result_value == '0)
	`MDU_ASSERT_IMPL(a_word_sext, done && word_q, rsp.result_value == sext32(rsp.result_value))

endmodule
